FILE: sv/dfe_pkg.sv
// ---------------------------------------------------------------------------
// dfe_pkg: shared definitions for the delimited frame extractor
// Byte type, delimiter codes and the threshold register format.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfe_pkg;

  typedef logic [7:0] byte_t;

  // Frame delimiters
  localparam byte_t START_CODE = 8'hFF;
  localparam byte_t END_CODE   = 8'hFE;

  // Minimum frame length register
  localparam int unsigned MIN_LEN_W = 7;
  typedef logic [MIN_LEN_W-1:0] min_len_t;
  localparam min_len_t MIN_LEN_RST = 7'd8;

endpackage

FILE: sv/delimited_frame_extractor.sv
// ---------------------------------------------------------------------------
// delimited_frame_extractor: start/end delimiter deframer
// Hunts for a 0xFF start code, collects bytes into a frame RAM until a 0xFE
// end code and delivers frames that reach min_frame_len as a run of beats.
//
// Input bytes are taken one per cycle while a frame is hunted or collected;
// a byte 0xFF restarts the frame, a frame longer than MaxFrameLen is dropped
// and a short one is discarded silently. When a qualifying frame closes,
// in_stall_o rises and the frame drains from the single read port of the
// frame RAM at one beat per cycle while out_stall_i is low, the first beat
// in the cycle after the closing input beat; the input side stays held
// until the last beat is taken. The RAM needs no clearing after reset,
// so the block takes input right out of reset. The threshold register is
// always ready and is meant to be written while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module delimited_frame_extractor #(
  parameter int unsigned MaxFrameLen = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // received bytes
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  // frame bytes
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    frame_byte_o,
  output logic                          frame_last_o,
  // threshold register
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dfe_pkg::MIN_LEN_W-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MaxFrameLen);
  localparam int unsigned LenW  = $clog2(MaxFrameLen + 1);
  localparam int unsigned CmpW  = ((LenW > dfe_pkg::MIN_LEN_W) ? LenW : dfe_pkg::MIN_LEN_W) + 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxFrameLen);

  logic                 in_acc;
  logic                 out_acc;
  dfe_pkg::min_len_t    min_len_q;
  logic                 collecting_q, collecting_d;
  logic [LenW-1:0]      frame_len_q, frame_len_d;
  logic [LenW-1:0]      len_inc;
  logic                 busy_q, busy_d;
  logic                 out_valid_q, out_valid_d;
  logic                 last_q, last_d;
  logic [AddrW-1:0]     rd_idx_q, rd_idx_d;
  logic [LenW-1:0]      rd_len_q, rd_len_d;
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  dfe_pkg::byte_t       ram_wdata;
  logic                 ram_re;
  logic [AddrW-1:0]     ram_raddr;
  dfe_pkg::byte_t       ram_rdata;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign len_inc = frame_len_q + LenW'(1);

  // threshold register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= dfe_pkg::MIN_LEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_len_q <= cfg_data_i;
    end
  end

  // collection and readout control
  always_comb begin
    collecting_d = collecting_q;
    frame_len_d  = frame_len_q;
    busy_d       = busy_q;
    out_valid_d  = out_valid_q;
    last_d       = last_q;
    rd_idx_d     = rd_idx_q;
    rd_len_d     = rd_len_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = rx_byte_i;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    if (in_acc) begin
      if (rx_byte_i == dfe_pkg::START_CODE) begin
        // start code always (re)starts the frame
        ram_we       = 1'b1;
        ram_waddr    = '0;
        frame_len_d  = LenW'(1);
        collecting_d = 1'b1;
      end else if (collecting_q) begin
        if (frame_len_q >= MaxLen) begin
          // overflow: drop frame and this byte
          collecting_d = 1'b0;
          frame_len_d  = '0;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = frame_len_q[AddrW-1:0];
          frame_len_d = len_inc;
          if (rx_byte_i == dfe_pkg::END_CODE) begin
            collecting_d = 1'b0;
            frame_len_d  = '0;
            if (CmpW'(len_inc) >= CmpW'(min_len_q)) begin
              // deliver: first read goes out now, byte 0 is not written here
              busy_d      = 1'b1;
              ram_re      = 1'b1;
              ram_raddr   = '0;
              out_valid_d = 1'b1;
              rd_idx_d    = '0;
              rd_len_d    = len_inc;
              last_d      = (len_inc == LenW'(1));
            end
          end
        end
      end
    end

    // drain one beat per accepted output
    if (out_acc) begin
      if (last_q) begin
        out_valid_d = 1'b0;
        busy_d      = 1'b0;
      end else begin
        ram_re    = 1'b1;
        ram_raddr = rd_idx_q + AddrW'(1);
        rd_idx_d  = ram_raddr;
        last_d    = ((LenW + 1)'(rd_idx_q) + (LenW + 1)'(2)) == (LenW + 1)'(rd_len_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      frame_len_q  <= '0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      last_q       <= 1'b0;
      rd_idx_q     <= '0;
      rd_len_q     <= '0;
    end else begin
      collecting_q <= collecting_d;
      frame_len_q  <= frame_len_d;
      busy_q       <= busy_d;
      out_valid_q  <= out_valid_d;
      last_q       <= last_d;
      rd_idx_q     <= rd_idx_d;
      rd_len_q     <= rd_len_d;
    end
  end

  // frame RAM
  dfe_ram #(
    .Width (8),
    .Depth (MaxFrameLen)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o   = busy_q;
  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = ram_rdata;
  assign frame_last_o = last_q;

`ifndef NO_ASSERTIONS
  // output beats only while input is held off
  a_out_implies_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("frame beat while input side open");

  // frame length never exceeds the RAM depth
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_len_q <= MaxLen)
    else $error("frame length beyond RAM depth");

  // every delivered frame opens with the start code
  a_first_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> frame_byte_o == dfe_pkg::START_CODE)
    else $error("frame does not open with start code");

  // the last beat carries the end code and closes the run
  a_last_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_last_o) |-> frame_byte_o == dfe_pkg::END_CODE)
    else $error("last beat is not the end code");

  a_last_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && frame_last_o) |=> (!out_valid_o && !in_stall_o))
    else $error("run continues after last beat");
`endif

endmodule

FILE: sv/dfe_ram.sv
// ---------------------------------------------------------------------------
// dfe_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read that holds its
// data while no read is issued.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
